@@ rtl/gsfa_pkg.sv @@
package gsfa_pkg;

    typedef enum logic [1:0] {
        MODE_ROW = 2'd0,   // first free slot in the requested row
        MODE_ISO = 2'd1,   // first slot with all four neighbors free
        MODE_RUN = 2'd2    // first run of adjacent free slots
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_NONE  = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] req_row;
        logic [3:0] run_length;
    } req_t;

    typedef struct packed {
        logic       granted;
        status_t    status;
        logic [1:0] out_row;
        logic [2:0] out_col;
    } rsp_t;

endpackage

@@ rtl/gsfa_if.sv @@
interface gsfa_req_if import gsfa_pkg::*; ();
    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface gsfa_rsp_if import gsfa_pkg::*; ();
    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/grid_slot_first_fit_allocator.sv @@
// channel | dir | beat payload                          | accepted when
// --------+-----+---------------------------------------+------------------------
// req     | in  | mode, req_row, run_length             | req.valid & req.ready
// rsp     | out | granted, status, out_row, out_col     | rsp.valid & rsp.ready
//
// One request at a time. req.ready is high only while idle.
// Range errors and unused modes answer in the cycle after the request beat.
// A scan reads one bitmap row per cycle: a row is evaluated once the row
// below it has come back from the memory.
// A grant ends the scan early; the result sits in rsp until taken.
// Reset marks every slot free at once through per-row valid bits.
module grid_slot_first_fit_allocator import gsfa_pkg::*; #(
    parameter int ROWS = 4,
    parameter int COLS = 8
) (
    input logic        clk,
    input logic        rst_n,
    gsfa_req_if.sink   req,
    gsfa_rsp_if.source rsp
);

    localparam int RW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CLW = $clog2(COLS);
    localparam int CW  = $clog2(ROWS + 2);
    localparam int NW  = $clog2(COLS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   step_reg;     // read pointer; evaluated row trails by two
    mode_t           mode_reg;
    logic [2:0]      req_row_reg;
    logic [COLS-1:0] len_mask_reg;
    logic [COLS-1:0] win_above_reg;
    logic [COLS-1:0] win_cur_reg;
    rsp_t            rsp_reg;

    logic [NW-1:0]   n_clamped;
    logic [COLS-1:0] len_mask_next;
    logic [COLS-1:0] rd_q;
    logic            rd_en;
    logic [RW-1:0]   ev_row;
    logic            eval_on;
    logic            row_ok;
    logic            last_step;
    logic            scan_hit;
    logic [CLW-1:0]  scan_col;
    logic [COLS-1:0] scan_take;
    logic            wr_en;
    logic [COLS-1:0] wr_data;
    logic [RW+1:0]   row_ext;
    logic [CLW+2:0]  col_ext;
    logic            range_err;
    logic            mode_bad;

    // run length clamped to 1..COLS, then turned into a mask of low ones
    always_comb
    begin
        if (req.payload.run_length == 4'd0)
        begin
            n_clamped = NW'(1);
        end
        else if (32'(req.payload.run_length) > COLS)
        begin
            n_clamped = NW'(COLS);
        end
        else
        begin
            n_clamped = NW'(req.payload.run_length);
        end
        for (int i = 0; i < COLS; i++)
        begin
            len_mask_next[i] = (32'(i) < 32'(n_clamped));
        end
    end

    assign range_err = (req.payload.mode == MODE_ROW) && (32'(req.payload.req_row) >= ROWS);
    assign mode_bad  = (req.payload.mode != MODE_ROW) && (req.payload.mode != MODE_ISO)
                    && (req.payload.mode != MODE_RUN);

    // scan pipeline: a read issued at step k is registered in rd_q; at step k, row k-2
    // is judged with win_above (k-3), win_cur (k-2) and the fresh read (k-1)
    assign rd_en     = (state_reg == S_SCAN) && (32'(step_reg) < ROWS);
    assign eval_on   = (state_reg == S_SCAN) && (step_reg >= CW'(2));
    assign ev_row    = RW'(step_reg - CW'(2));
    assign last_step = (32'(step_reg) == ROWS + 1);
    assign row_ok    = eval_on
                    && ((mode_reg != MODE_ROW) || (32'(ev_row) == 32'(req_row_reg)));

    gsfa_bitmap #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_bitmap (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (RW'(step_reg)),
        .rd_q    (rd_q),
        .wr_en   (wr_en),
        .wr_addr (ev_row),
        .wr_data (wr_data)
    );

    gsfa_scan #(
        .COLS (COLS)
    ) u_scan (
        .mode     (mode_reg),
        .row      (win_cur_reg),
        .above    (win_above_reg),
        .below    (rd_q),
        .len_mask (len_mask_reg),
        .hit      (scan_hit),
        .col      (scan_col),
        .take     (scan_take)
    );

    assign wr_en   = row_ok && scan_hit;
    assign wr_data = win_cur_reg | scan_take;
    assign row_ext = (RW + 2)'(ev_row);
    assign col_ext = (CLW + 3)'(scan_col);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            mode_reg      <= MODE_ROW;
            req_row_reg   <= '0;
            len_mask_reg  <= '0;
            win_above_reg <= '0;
            win_cur_reg   <= '0;
            rsp_reg       <= '{granted: 1'b0, status: ST_OK, out_row: 2'd0, out_col: 3'd0};
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        mode_reg      <= mode_t'(req.payload.mode);
                        req_row_reg   <= req.payload.req_row;
                        len_mask_reg  <= len_mask_next;
                        step_reg      <= '0;
                        win_above_reg <= '0;
                        win_cur_reg   <= '0;
                        if (range_err)
                        begin
                            rsp_reg   <= '{granted: 1'b0, status: ST_RANGE,
                                           out_row: 2'd0, out_col: 3'd0};
                            state_reg <= S_RESP;
                        end
                        else if (mode_bad)
                        begin
                            rsp_reg   <= '{granted: 1'b0, status: ST_NONE,
                                           out_row: 2'd0, out_col: 3'd0};
                            state_reg <= S_RESP;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    step_reg      <= step_reg + CW'(1);
                    win_above_reg <= win_cur_reg;
                    win_cur_reg   <= rd_q;
                    if (wr_en)
                    begin
                        rsp_reg   <= '{granted: 1'b1, status: ST_OK,
                                       out_row: row_ext[1:0], out_col: col_ext[2:0]};
                        state_reg <= S_RESP;
                    end
                    else if (last_step)
                    begin
                        rsp_reg   <= '{granted: 1'b0, status: ST_NONE,
                                       out_row: 2'd0, out_col: 3'd0};
                        state_reg <= S_RESP;
                    end
                end
                S_RESP:
                begin
                    if (rsp.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = (state_reg == S_RESP);
    assign rsp.payload = rsp_reg;

    // a grant and an ok status always travel together
    a_grant_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.payload.granted == (rsp.payload.status == ST_OK)))
        else $error("granted and status disagree");

    // a bitmap update is always followed by a granted response
    a_write_grants: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (state_reg == S_RESP) && rsp_reg.granted)
        else $error("bitmap written without a grant");

    // single-slot modes set exactly one bit that was free before
    a_single_take: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && (mode_reg != MODE_RUN))
            |-> (($countones(wr_data ^ win_cur_reg) == 1)
                 && ((wr_data & win_cur_reg) == win_cur_reg)))
        else $error("single-slot grant did not take exactly one free slot");

    // the scan never runs past its last evaluated row
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (32'(step_reg) <= ROWS + 1))
        else $error("scan pointer overran the grid");

    // no new request while a response waits
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && rsp.valid))
        else $error("request taken while response pending");

endmodule

@@ rtl/gsfa_bitmap.sv @@
module gsfa_bitmap import gsfa_pkg::*; #(
    parameter int ROWS = 4,
    parameter int COLS = 8,
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            rd_en,
    input  logic [RW-1:0]   rd_addr,
    output logic [COLS-1:0] rd_q,
    input  logic            wr_en,
    input  logic [RW-1:0]   wr_addr,
    input  logic [COLS-1:0] wr_data
);

    logic [COLS-1:0] mem [ROWS];
    logic [ROWS-1:0] row_vld_reg;
    logic [COLS-1:0] rd_q_reg;

    // row valid bits: an unwritten row reads as all free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
        end
        else if (wr_en)
        begin
            row_vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data is zero in the cycle after an idle read port or a read of an unwritten row
    always_ff @(posedge clk)
    begin
        if (rd_en && row_vld_reg[rd_addr])
        begin
            rd_q_reg <= mem[rd_addr];
        end
        else
        begin
            rd_q_reg <= '0;
        end
    end

    assign rd_q = rd_q_reg;

endmodule

@@ rtl/gsfa_scan.sv @@
module gsfa_scan import gsfa_pkg::*; #(
    parameter int COLS = 8,
    localparam int CLW = $clog2(COLS)
) (
    input  mode_t            mode,
    input  logic [COLS-1:0]  row,
    input  logic [COLS-1:0]  above,
    input  logic [COLS-1:0]  below,
    input  logic [COLS-1:0]  len_mask,
    output logic             hit,
    output logic [CLW-1:0]   col,
    output logic [COLS-1:0]  take
);

    logic [2*COLS-1:0] padded;
    logic [COLS-1:0]   cand;

    // columns past the edge count as busy so a run cannot spill over
    assign padded = {{COLS{1'b1}}, row};

    always_comb
    begin
        cand = '0;
        case (mode)
            MODE_ROW: cand = ~row;
            MODE_ISO: cand = ~(row | (row << 1) | (row >> 1) | above | below);
            MODE_RUN:
            begin
                for (int c = 0; c < COLS; c++)
                begin
                    cand[c] = ~|(padded[c +: COLS] & len_mask);
                end
            end
            default: cand = '0;
        endcase
    end

    // lowest candidate column wins
    always_comb
    begin
        col = '0;
        for (int c = COLS - 1; c >= 0; c--)
        begin
            if (cand[c])
            begin
                col = CLW'(c);
            end
        end
    end

    assign hit  = |cand;
    assign take = ((mode == MODE_RUN) ? len_mask : COLS'(1)) << col;

endmodule

@@ tb/sv/gsfa_checker.sv @@
`timescale 1ns / 100ps

module gsfa_checker import gsfa_pkg::*; #(
    parameter int ROWS = 4,
    parameter int COLS = 8
) (
    input  logic clk,
    input  logic rst_n,
    gsfa_req_if  req,
    gsfa_rsp_if  rsp,
    output int   fail_count,
    output int   awaited
);

    logic [COLS-1:0] occupied [ROWS];
    rsp_t            answers_due [$];

    // off-grid neighbors count as free
    function automatic bit slot_busy(int r, int c);
        if (r < 0 || r >= ROWS || c < 0 || c >= COLS)
            return 1'b0;
        return occupied[r][c];
    endfunction

    function automatic rsp_t grant_at(int r, int c);
        rsp_t ans;
        ans.granted = 1'b1;
        ans.status  = ST_OK;
        ans.out_row = 2'(r);
        ans.out_col = 3'(c);
        return ans;
    endfunction

    // Updates the bitmap copy and returns the answer for one request beat.
    function automatic rsp_t allocate(req_t item);
        rsp_t ans;
        int   n;
        int   run;
        ans.granted = 1'b0;
        ans.status  = ST_NONE;
        ans.out_row = '0;
        ans.out_col = '0;
        case (item.mode)
            MODE_ROW:
            begin
                if (item.req_row >= ROWS)
                    ans.status = ST_RANGE;
                else
                    for (int c = 0; c < COLS; c++)
                        if (!slot_busy(item.req_row, c))
                        begin
                            occupied[item.req_row][c] = 1'b1;
                            return grant_at(item.req_row, c);
                        end
            end
            MODE_ISO:
            begin
                for (int r = 0; r < ROWS; r++)
                    for (int c = 0; c < COLS; c++)
                        if (!slot_busy(r, c) && !slot_busy(r, c - 1) && !slot_busy(r, c + 1)
                            && !slot_busy(r - 1, c) && !slot_busy(r + 1, c))
                        begin
                            occupied[r][c] = 1'b1;
                            return grant_at(r, c);
                        end
            end
            MODE_RUN:
            begin
                n = item.run_length;
                if (n < 1)
                    n = 1;
                if (n > COLS)
                    n = COLS;
                for (int r = 0; r < ROWS; r++)
                begin
                    run = 0;
                    for (int c = 0; c < COLS; c++)
                    begin
                        run = slot_busy(r, c) ? 0 : run + 1;
                        if (run == n)
                        begin
                            for (int k = c + 1 - n; k <= c; k++)
                                occupied[r][k] = 1'b1;
                            return grant_at(r, c + 1 - n);
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        return ans;
    endfunction

    task automatic check_field(string field, logic [2:0] want, logic [2:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            foreach (occupied[r])
                occupied[r] = '0;
            answers_due.delete();
            fail_count = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (answers_due.size() == 0)
                begin
                    $display("%0t ns: result beat with none expected, got %p",
                             $time, rsp.payload);
                    fail_count++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    check_field("granted", want.granted, rsp.payload.granted);
                    check_field("status", want.status, rsp.payload.status);
                    check_field("out_row", want.out_row, rsp.payload.out_row);
                    check_field("out_col", want.out_col, rsp.payload.out_col);
                end
            end
            if (req.valid && req.ready)
                answers_due.push_back(allocate(req.payload));
        end
        awaited = answers_due.size();
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import gsfa_pkg::*;

    localparam int ROWS = 4;
    localparam int COLS = 8;
    localparam int RANDOM_ITEMS = 1500;
    // mode code with no allocation behind it
    localparam logic [1:0] MODE_SPARE = 2'd3;

    logic clk;
    logic rst_n;
    int   fails;
    int   awaited;
    bit   calm_req;   // set: requests go back to back
    bit   calm_rsp;   // set: results taken at once

    gsfa_req_if req_ch ();
    gsfa_rsp_if rsp_ch ();

    grid_slot_first_fit_allocator #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .rsp(rsp_ch)
    );

    // Watches both channels, keeps its own bitmap and compares each result beat.
    gsfa_checker #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) chk (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .rsp(rsp_ch),
        .fail_count(fails),
        .awaited(awaited)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Idle length: mostly none, some short, a few long.
    function automatic int idle_gap(bit calm);
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(99);
        if (roll < 60)
            return 0;
        if (roll < 93)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Drives one request beat at the falling edge and returns right after the
    // rising edge that accepted it. valid is left high so that a back-to-back
    // beat never lowers and raises it within one time step.
    task automatic send_req(logic [1:0] mode, logic [2:0] row, logic [3:0] len);
        int gap;
        gap = idle_gap(calm_req);
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= '{mode: mode, req_row: row, run_length: len};
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Result side: ready changes only at falling edges, with stalls of random
    // length and quiet stretches where every result is taken at once.
    initial
    begin
        int stall;
        int cycle;
        stall        = 0;
        cycle        = 0;
        calm_rsp     = 1'b0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            cycle++;
            if (cycle % 256 == 0)
                calm_rsp = ($urandom_range(3) == 0);
            if (stall > 0)
                stall--;
            else
                stall = idle_gap(calm_rsp);
            rsp_ch.ready <= (stall == 0);
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        calm_req       = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. The grid is 4 x 8 and nothing is ever freed, so the
        // order below walks it from empty to full.
        send_req(MODE_ISO, 3'd7, 4'd15);   // empty grid: corner slot (0,0)
        send_req(MODE_ISO, 3'd0, 4'd0);    // left neighbor busy, lands at (0,2)
        send_req(MODE_ROW, 3'd0, 4'd15);   // lowest free column in row 0
        send_req(MODE_ROW, 3'd7, 4'd0);    // row out of range, widest code
        send_req(MODE_ROW, 3'd4, 4'd3);    // first row past the grid
        send_req(MODE_RUN, 3'd5, 4'd0);    // zero length acts as one slot
        send_req(MODE_RUN, 3'd0, 4'd15);   // clamped to a full row: row 1
        send_req(MODE_RUN, 3'd3, 4'd8);    // exactly one row: row 2
        send_req(MODE_SPARE, 3'd0, 4'd1);  // unused mode answers nothing free
        send_req(MODE_ISO, 3'd2, 4'd7);    // no slot with four free neighbors
        send_req(MODE_RUN, 3'd1, 4'd4);    // first fitting run is the tail of row 0
        send_req(MODE_ROW, 3'd1, 4'd2);    // full row
        send_req(MODE_RUN, 3'd6, 4'd9);    // clamped run takes the last row
        send_req(MODE_ROW, 3'd3, 4'd0);    // grid now full
        send_req(MODE_ROW, 3'd0, 4'd0);
        send_req(MODE_RUN, 3'd0, 4'd1);
        send_req(MODE_ISO, 3'd0, 4'd0);
        send_req(MODE_SPARE, 3'd7, 4'd15);
        send_req(MODE_ROW, 3'd5, 4'd15);   // range check still wins on a full grid

        // Random part: every field over its full width, unused mode now and then,
        // with quiet stretches on the request side every 64 beats.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 64 == 0)
                calm_req = ($urandom_range(3) == 0);
            send_req(($urandom_range(9) == 0) ? MODE_SPARE : 2'($urandom_range(2)),
                     3'($urandom_range(7)), 4'($urandom_range(15)));
        end
        @(negedge clk);
        req_ch.valid <= 1'b0;

        // Drain, then give the block time to show any stray result beat.
        wait (awaited == 0);
        repeat (4 * (ROWS + 2)) @(posedge clk);
        if (fails == 0)
            $display("PASS grid_slot_first_fit_allocator");
        else
            $display("FAIL grid_slot_first_fit_allocator");
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial
    begin
        #15ms;
        $display("FAIL grid_slot_first_fit_allocator");
        $finish;
    end

endmodule
